// ===== hw/rtl/tnss_pkg.sv =====
// shared types and constants of the top-n score selector
`timescale 1ns / 1ps

package tnss_pkg;

    localparam int MAX_RESULTS     = 8;
    localparam int TOP_COUNT_W     = 4;
    localparam int RANK_W          = 3;
    localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } tnss_state_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
        logic clear;
    } tnss_ctrl_t;

endpackage

// ===== hw/rtl/tnss_cell.sv =====
// one slot of the sorted chain: compare, insert, shift and clear
`timescale 1ns / 1ps

module tnss_cell #(
    parameter int SCORE_W = 16,
    parameter int IDX_W   = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tnss_pkg::tnss_ctrl_t ctrl,
    input  logic [SCORE_W-1:0]  new_score,
    input  logic [IDX_W-1:0]    new_index,
    input  logic                prev_take,
    input  logic                prev_valid,
    input  logic [IDX_W-1:0]    prev_index,
    input  logic [SCORE_W-1:0]  prev_score,
    input  logic                next_valid,
    input  logic [IDX_W-1:0]    next_index,
    input  logic [SCORE_W-1:0]  next_score,
    output logic                take,
    output logic                valid,
    output logic [IDX_W-1:0]    index,
    output logic [SCORE_W-1:0]  score
);
    import tnss_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [IDX_W-1:0]   index_reg;
    logic [IDX_W-1:0]   index_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;

    assign take = !valid_reg || (new_score > score_reg);

    always_comb
    begin
        valid_next = valid_reg;
        index_next = index_reg;
        score_next = score_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_out)
        begin
            valid_next = next_valid;
            index_next = next_index;
            score_next = next_score;
        end
        else if (ctrl.insert)
        begin
            if (prev_take)
            begin
                valid_next = prev_valid;
                index_next = prev_index;
                score_next = prev_score;
            end
            else if (take)
            begin
                valid_next = 1'b1;
                index_next = new_index;
                score_next = new_score;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        score_reg <= score_next;
    end

    assign valid = valid_reg;
    assign index = index_reg;
    assign score = score_reg;

endmodule

// ===== hw/rtl/top_n_score_selector_core.sv =====
// top level: chain of sorted cells, set position counter and report sequencer
//
// usage
// - input channel: a transfer happens at a rising edge with start high and busy low;
//   score and last are sampled there, one item per cycle while busy stays low
// - each item is numbered by its position in the set and inserted into a sorted
//   chain of MAX_TOP cells in the same cycle; items past MAX_ITEMS are dropped
// - the item with last set starts a report: busy rises on the next cycle and the
//   chain shifts toward cell 0 once per cycle, giving top_count results best first
// - results: strobe marks one transfer per cycle with rank, item_index, best_score,
//   slot_valid and final_res; the receiver cannot stall, nothing is held back
// - the first result comes in the cycle after the last item, then one per cycle
// - after the result with final_res the store and position clear and busy drops
// - cfg_we writes top_count (0 reads as 1, values above 8 or MAX_TOP are capped);
//   the value at the last item sets the result count
// - reset: store empty, position zero, top_count 8, block idle
`timescale 1ns / 1ps

module top_n_score_selector_core #(
    parameter int MAX_TOP    = 8,
    parameter int MAX_ITEMS  = 1024,
    parameter int SCORE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [SCORE_BITS-1:0]                  score,
    input  logic                                   last,
    input  logic                                   cfg_we,
    input  logic [tnss_pkg::TOP_COUNT_W-1:0]       cfg_data,
    output logic                                   strobe,
    output logic [tnss_pkg::RANK_W-1:0]            rank,
    output logic [$clog2(MAX_ITEMS)-1:0]           item_index,
    output logic [SCORE_BITS-1:0]                  best_score,
    output logic                                   slot_valid,
    output logic                                   final_res
);
    import tnss_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int POS_W = $clog2(MAX_ITEMS + 1);
    localparam int LIM   = (MAX_TOP < MAX_RESULTS) ? MAX_TOP : MAX_RESULTS;

    tnss_state_t              state_reg;
    tnss_state_t              state_next;
    logic [TOP_COUNT_W-1:0]   top_count_reg;
    logic [TOP_COUNT_W-1:0]   n_reg;
    logic [TOP_COUNT_W-1:0]   n_next;
    logic [TOP_COUNT_W-1:0]   n_clamped;
    logic [RANK_W-1:0]        k_reg;
    logic [RANK_W-1:0]        k_next;
    logic [POS_W-1:0]         position_reg;
    logic [POS_W-1:0]         position_next;
    logic                     accept;
    logic                     in_range;
    logic                     is_final;
    tnss_ctrl_t               ctrl;

    logic                     take_w  [MAX_TOP];
    logic                     valid_w [MAX_TOP];
    logic [IDX_W-1:0]         index_w [MAX_TOP];
    logic [SCORE_BITS-1:0]    score_w [MAX_TOP];

    assign accept   = start && !busy;
    assign in_range = position_reg < POS_W'(MAX_ITEMS);
    assign is_final = (state_reg == ST_REPORT) &&
                      ((TOP_COUNT_W'(k_reg) + TOP_COUNT_W'(1)) == n_reg);

    always_comb
    begin
        if (top_count_reg == '0)
            n_clamped = TOP_COUNT_W'(1);
        else if (top_count_reg > TOP_COUNT_W'(LIM))
            n_clamped = TOP_COUNT_W'(LIM);
        else
            n_clamped = top_count_reg;
    end

    always_comb
    begin
        ctrl.insert    = accept && in_range;
        ctrl.shift_out = (state_reg == ST_REPORT) && !is_final;
        ctrl.clear     = is_final;
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        position_next = position_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_range)
                        position_next = position_reg + POS_W'(1);
                    if (last)
                    begin
                        state_next = ST_REPORT;
                        n_next     = n_clamped;
                        k_next     = '0;
                    end
                end
            end
            ST_REPORT:
            begin
                if (is_final)
                begin
                    state_next    = ST_IDLE;
                    position_next = '0;
                end
                else
                begin
                    k_next = k_reg + RANK_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_count_reg <= TOP_COUNT_RESET;
            n_reg         <= TOP_COUNT_RESET;
            k_reg         <= '0;
            position_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            position_reg <= position_next;
            if (cfg_we)
                top_count_reg <= cfg_data;
        end
    end

    // sorted chain, cell 0 holds the best entry
    generate
        for (genvar i = 0; i < MAX_TOP; i++)
        begin : g_cell
            logic                  prev_take;
            logic                  prev_valid;
            logic [IDX_W-1:0]      prev_index;
            logic [SCORE_BITS-1:0] prev_score;
            logic                  next_valid;
            logic [IDX_W-1:0]      next_index;
            logic [SCORE_BITS-1:0] next_score;

            if (i == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_valid = 1'b0;
                assign prev_index = '0;
                assign prev_score = '0;
            end
            else
            begin : g_body
                assign prev_take  = take_w[i-1];
                assign prev_valid = valid_w[i-1];
                assign prev_index = index_w[i-1];
                assign prev_score = score_w[i-1];
            end

            if (i == MAX_TOP - 1)
            begin : g_tail
                assign next_valid = 1'b0;
                assign next_index = '0;
                assign next_score = '0;
            end
            else
            begin : g_inner
                assign next_valid = valid_w[i+1];
                assign next_index = index_w[i+1];
                assign next_score = score_w[i+1];
            end

            tnss_cell #(
                .SCORE_W (SCORE_BITS),
                .IDX_W   (IDX_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_score  (score),
                .new_index  (position_reg[IDX_W-1:0]),
                .prev_take  (prev_take),
                .prev_valid (prev_valid),
                .prev_index (prev_index),
                .prev_score (prev_score),
                .next_valid (next_valid),
                .next_index (next_index),
                .next_score (next_score),
                .take       (take_w[i]),
                .valid      (valid_w[i]),
                .index      (index_w[i]),
                .score      (score_w[i])
            );
        end
    endgenerate

    assign busy       = (state_reg == ST_REPORT);
    assign strobe     = (state_reg == ST_REPORT);
    assign rank       = k_reg;
    assign slot_valid = valid_w[0];
    assign item_index = valid_w[0] ? index_w[0] : '0;
    assign best_score = valid_w[0] ? score_w[0] : '0;
    assign final_res  = is_final;

`ifndef NO_ASSERTIONS
    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> (strobe && rank == '0))
        else $error("report did not start after last item");

    a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !final_res) |=> (strobe && rank == $past(rank) + RANK_W'(1)))
        else $error("rank did not advance during report");

    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && final_res) |=> (!busy && position_reg == '0 && !slot_valid))
        else $error("store not cleared after final result");

    a_no_idle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !(start && last)) |=> !strobe)
        else $error("result transfer without last item");
`endif

endmodule

// ===== test/tb_top_n_score_selector_core.sv =====
// testbench for the top-n score selector core: score sets checked against a sorted-list predictor
`timescale 1ns / 1ps

module tb_top_n_score_selector_core;
    import tnss_pkg::*;

    localparam int MAX_TOP        = 8;
    localparam int MAX_ITEMS      = 1024;
    localparam int SCORE_BITS     = 16;
    localparam int INDEX_W        = $clog2(MAX_ITEMS);
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [RANK_W-1:0]     rank;
        logic [INDEX_W-1:0]    item_index;
        logic [SCORE_BITS-1:0] best_score;
        logic                  slot_valid;
        logic                  final_res;
    } ranked_entry_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [SCORE_BITS-1:0]  score;
    logic                   last;
    logic                   cfg_we;
    logic [TOP_COUNT_W-1:0] cfg_data;
    logic                   strobe;
    logic [RANK_W-1:0]      rank;
    logic [INDEX_W-1:0]     item_index;
    logic [SCORE_BITS-1:0]  best_score;
    logic                   slot_valid;
    logic                   final_res;

    logic [INDEX_W-1:0]     keep_idx [MAX_TOP];
    logic [SCORE_BITS-1:0]  keep_sc  [MAX_TOP];
    logic                   keep_vld [MAX_TOP];
    logic [INDEX_W:0]       set_pos;
    logic [TOP_COUNT_W-1:0] model_top_count;
    ranked_entry_t          expected_ranks [$];
    ranked_entry_t          want;

    int err_count    = 0;
    int items_sent   = 0;
    int sets_done    = 0;
    int results_seen = 0;
    int idle_pct     = 0;
    int idle_cycles  = 0;

    top_n_score_selector_core #(
        .MAX_TOP    (MAX_TOP),
        .MAX_ITEMS  (MAX_ITEMS),
        .SCORE_BITS (SCORE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .score      (score),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .rank       (rank),
        .item_index (item_index),
        .best_score (best_score),
        .slot_valid (slot_valid),
        .final_res  (final_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_store();
        int i;
        for (i = 0; i < MAX_TOP; i++)
        begin
            keep_idx[i] = '0;
            keep_sc[i]  = '0;
            keep_vld[i] = 1'b0;
        end
        set_pos = '0;
    endfunction

    function automatic void insert_candidate(input logic [INDEX_W-1:0] idx,
                                             input logic [SCORE_BITS-1:0] sc);
        int j;
        int k;
        j = 0;
        while (j < MAX_TOP && keep_vld[j] && !(sc > keep_sc[j]))
            j++;
        if (j < MAX_TOP)
        begin
            for (k = MAX_TOP - 1; k > j; k--)
            begin
                keep_idx[k] = keep_idx[k-1];
                keep_sc[k]  = keep_sc[k-1];
                keep_vld[k] = keep_vld[k-1];
            end
            keep_idx[j] = idx;
            keep_sc[j]  = sc;
            keep_vld[j] = 1'b1;
        end
    endfunction

    function automatic void emit_ranking();
        int n;
        int k;
        ranked_entry_t e;
        n = int'(model_top_count);
        if (n < 1)
            n = 1;
        if (n > MAX_RESULTS)
            n = MAX_RESULTS;
        if (n > MAX_TOP)
            n = MAX_TOP;
        for (k = 0; k < n; k++)
        begin
            e.rank       = k[RANK_W-1:0];
            e.item_index = keep_vld[k] ? keep_idx[k] : '0;
            e.best_score = keep_vld[k] ? keep_sc[k] : '0;
            e.slot_valid = keep_vld[k];
            e.final_res  = (k + 1 == n);
            expected_ranks = {expected_ranks, e};
        end
        clear_store();
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_store();
            model_top_count = TOP_COUNT_RESET;
            expected_ranks.delete();
        end
        else
        begin
            if (strobe)
            begin
                results_seen++;
                if (expected_ranks.size() == 0)
                begin
                    $error("result with nothing expected: rank %0d index %0d", rank, item_index);
                    err_count++;
                end
                else
                begin
                    want = expected_ranks.pop_front();
                    check_field("rank", 32'(want.rank), 32'(rank));
                    check_field("item_index", 32'(want.item_index), 32'(item_index));
                    check_field("best_score", 32'(want.best_score), 32'(best_score));
                    check_field("slot_valid", 32'(want.slot_valid), 32'(slot_valid));
                    check_field("final_res", 32'(want.final_res), 32'(final_res));
                end
            end
            // input transfer: start high while busy low
            if (start && !busy)
            begin
                items_sent++;
                if (set_pos < MAX_ITEMS)
                begin
                    insert_candidate(set_pos[INDEX_W-1:0], score);
                    set_pos++;
                end
                if (last)
                begin
                    emit_ranking();
                    sets_done++;
                end
            end
            if (cfg_we)
                model_top_count = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || cfg_we)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [SCORE_BITS-1:0] sc, input logic lst);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        score <= sc;
        last  <= lst;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_ranks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_top_count(input logic [TOP_COUNT_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [SCORE_BITS-1:0] random_score();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCORE_BITS'($urandom_range(0, 3));
            default: return SCORE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_item(16'd100, 1'b0);
        send_item(16'd300, 1'b0);
        send_item(16'd200, 1'b1);
        drain_results();
    endtask

    task automatic test_ties_and_extremes();
        logic [SCORE_BITS-1:0] seq [10];
        int i;
        seq = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000,
                16'h8000, 16'h0001, 16'hFFFE, 16'hFFFF, 16'h7FFF};
        write_top_count(4'd8);
        for (i = 0; i < 10; i++)
            send_item(seq[i], i == 9);
        drain_results();
    endtask

    task automatic test_count_range();
        logic [TOP_COUNT_W-1:0] vals [4];
        int i;
        vals = '{4'd0, 4'd15, 4'd1, 4'd9};
        for (i = 0; i < 4; i++)
        begin
            write_top_count(vals[i]);
            send_item(random_score(), 1'b0);
            send_item(random_score(), 1'b1);
        end
        drain_results();
    endtask

    task automatic test_midset_config();
        write_top_count(4'd2);
        send_item(16'd5, 1'b0);
        send_item(16'd9, 1'b0);
        send_item(16'd7, 1'b0);
        write_top_count(4'd5);
        send_item(16'd9, 1'b1);
        drain_results();
    endtask

    task automatic run_random_phase(input int pct, input logic [TOP_COUNT_W-1:0] count,
                                    input int n_items);
        int sent;
        int set_len;
        int i;
        write_top_count(count);
        idle_pct = pct;
        sent = 0;
        while (sent < n_items)
        begin
            set_len = $urandom_range(1, 12);
            for (i = 0; i < set_len; i++)
                send_item(random_score(), i == set_len - 1);
            sent += set_len;
        end
        drain_results();
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        score    <= '0;
        last     <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ties_and_extremes();
        test_count_range();
        test_midset_config();
        run_random_phase(0, 4'd8, 18);
        run_random_phase(59, 4'($urandom_range(1, 8)), 18);
        run_random_phase(0, 4'd1, 18);
        run_random_phase(23, 4'($urandom_range(0, 15)), 18);

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d items in %0d sets, %0d results checked",
                 items_sent, sets_done, results_seen);
        $display("top counts 0, 1, 8, 9 and 15, ties, empty slots and a count change mid-set");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tnss_pkg.sv
hw/rtl/tnss_cell.sv
hw/rtl/top_n_score_selector_core.sv
test/tb_top_n_score_selector_core.sv
